/* rtl/ffha_pkg.sv */
// Shared types, codes and constants for the first-fit heap allocator.
package ffha_pkg;

  localparam int unsigned BLK_CNT_W = 9;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } command_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_SIZE = 3'd1,
    ST_BIG      = 3'd2,
    ST_NO_HEAP  = 3'd3,
    ST_FULL     = 3'd4,
    ST_IGNORED  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CFG_HEAP_LIMIT  = 2'd0,
    CFG_SPLIT_THR   = 2'd1,
    CFG_BIG_THR     = 2'd2,
    CFG_MAX_REQUEST = 2'd3
  } cfg_index_t;

  localparam logic [31:0] HEAP_LIMIT_RST  = 32'd16777216;
  localparam logic [15:0] SPLIT_THR_RST   = 16'd128;
  localparam logic [31:0] BIG_THR_RST     = 32'd128000;
  localparam logic [31:0] MAX_REQUEST_RST = 32'd100000000;

  typedef struct packed {
    logic        command;
    logic [31:0] alloc_size;
    logic [31:0] payload_address;
  } req_t;

  typedef struct packed {
    logic [31:0]          result_address;
    status_t              status;
    logic [BLK_CNT_W-1:0] avail_blocks;
    logic [31:0]          avail_bytes;
    logic [BLK_CNT_W-1:0] used_blocks;
    logic [31:0]          used_bytes;
    logic [31:0]          header_bytes;
  } rsp_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
    logic        free;
  } entry_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_FAIL,
    OP_READ_IDX,
    OP_INC,
    OP_HIT,
    OP_GROW,
    OP_APPEND,
    OP_SETUP_UP,
    OP_READ_UP,
    OP_WRITE_UP,
    OP_SPLIT,
    OP_TAKE,
    OP_TAKE_SPLIT,
    OP_MARK,
    OP_READ_NX,
    OP_MERGE_NX,
    OP_READ_DN,
    OP_WRITE_DN,
    OP_DN_DONE,
    OP_READ_PV,
    OP_MERGE_PV,
    OP_WB_FIN,
    OP_DN_FIN,
    OP_FIN_IGNORE
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_NOTFOUND,
    S_ALLOC_HIT,
    S_UP_RD,
    S_UP_WR,
    S_TAKE_SPLIT,
    S_FREE_HIT,
    S_NX_RD,
    S_NX_CHK,
    S_DN1_RD,
    S_DN1_WR,
    S_PV_RD,
    S_PV_CHK,
    S_DN2_RD,
    S_DN2_WR
  } state_t;

  typedef struct packed {
    logic is_free;
    logic pre_fail;
    logic scan_end;
    logic match;
    logic last_free;
    logic ent_free;
    logic split_ok;
    logic has_next;
    logic has_prev;
    logic rd_free;
    logic up_done;
    logic dn_done;
  } flags_t;

endpackage

/* rtl/ffha_ctrl.sv */
// Sequencer for the allocator: scan, shift and merge steps.
module ffha_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  ffha_pkg::flags_t flags,
  output ffha_pkg::op_t   op,
  output logic            busy
);

  ffha_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffha_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ffha_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      ffha_pkg::S_IDLE:       if (start) state_next = ffha_pkg::S_CHECK;
      ffha_pkg::S_CHECK:      state_next = flags.pre_fail ? ffha_pkg::S_IDLE : ffha_pkg::S_SCAN_RD;
      ffha_pkg::S_SCAN_RD: begin
        if (!flags.scan_end) state_next = ffha_pkg::S_SCAN_CHK;
        else if (flags.is_free) state_next = ffha_pkg::S_IDLE;
        else state_next = ffha_pkg::S_NOTFOUND;
      end
      ffha_pkg::S_SCAN_CHK: begin
        if (!flags.match) state_next = ffha_pkg::S_SCAN_RD;
        else if (flags.is_free) state_next = ffha_pkg::S_FREE_HIT;
        else state_next = ffha_pkg::S_ALLOC_HIT;
      end
      ffha_pkg::S_NOTFOUND:   state_next = ffha_pkg::S_IDLE;
      ffha_pkg::S_ALLOC_HIT:  state_next = flags.split_ok ? ffha_pkg::S_UP_RD : ffha_pkg::S_IDLE;
      ffha_pkg::S_UP_RD:      state_next = flags.up_done ? ffha_pkg::S_TAKE_SPLIT
                                                         : ffha_pkg::S_UP_WR;
      ffha_pkg::S_UP_WR:      state_next = ffha_pkg::S_UP_RD;
      ffha_pkg::S_TAKE_SPLIT: state_next = ffha_pkg::S_IDLE;
      ffha_pkg::S_FREE_HIT:   state_next = flags.ent_free ? ffha_pkg::S_IDLE : ffha_pkg::S_NX_RD;
      ffha_pkg::S_NX_RD:      state_next = flags.has_next ? ffha_pkg::S_NX_CHK : ffha_pkg::S_PV_RD;
      ffha_pkg::S_NX_CHK:     state_next = flags.rd_free ? ffha_pkg::S_DN1_RD : ffha_pkg::S_PV_RD;
      ffha_pkg::S_DN1_RD:     state_next = flags.dn_done ? ffha_pkg::S_PV_RD : ffha_pkg::S_DN1_WR;
      ffha_pkg::S_DN1_WR:     state_next = ffha_pkg::S_DN1_RD;
      ffha_pkg::S_PV_RD:      state_next = flags.has_prev ? ffha_pkg::S_PV_CHK : ffha_pkg::S_IDLE;
      ffha_pkg::S_PV_CHK:     state_next = flags.rd_free ? ffha_pkg::S_DN2_RD : ffha_pkg::S_IDLE;
      ffha_pkg::S_DN2_RD:     state_next = flags.dn_done ? ffha_pkg::S_IDLE : ffha_pkg::S_DN2_WR;
      ffha_pkg::S_DN2_WR:     state_next = ffha_pkg::S_DN2_RD;
      default:                state_next = ffha_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    op = ffha_pkg::OP_NONE;
    unique case (state)
      ffha_pkg::S_IDLE:       if (start) op = ffha_pkg::OP_LOAD;
      ffha_pkg::S_CHECK:      if (flags.pre_fail) op = ffha_pkg::OP_FAIL;
      ffha_pkg::S_SCAN_RD: begin
        if (!flags.scan_end) op = ffha_pkg::OP_READ_IDX;
        else if (flags.is_free) op = ffha_pkg::OP_FIN_IGNORE;
      end
      ffha_pkg::S_SCAN_CHK:   op = flags.match ? ffha_pkg::OP_HIT : ffha_pkg::OP_INC;
      ffha_pkg::S_NOTFOUND:   op = flags.last_free ? ffha_pkg::OP_GROW : ffha_pkg::OP_APPEND;
      ffha_pkg::S_ALLOC_HIT:  op = flags.split_ok ? ffha_pkg::OP_SETUP_UP : ffha_pkg::OP_TAKE;
      ffha_pkg::S_UP_RD:      op = flags.up_done ? ffha_pkg::OP_SPLIT : ffha_pkg::OP_READ_UP;
      ffha_pkg::S_UP_WR:      op = ffha_pkg::OP_WRITE_UP;
      ffha_pkg::S_TAKE_SPLIT: op = ffha_pkg::OP_TAKE_SPLIT;
      ffha_pkg::S_FREE_HIT:   op = flags.ent_free ? ffha_pkg::OP_FIN_IGNORE : ffha_pkg::OP_MARK;
      ffha_pkg::S_NX_RD:      if (flags.has_next) op = ffha_pkg::OP_READ_NX;
      ffha_pkg::S_NX_CHK:     if (flags.rd_free) op = ffha_pkg::OP_MERGE_NX;
      ffha_pkg::S_DN1_RD:     op = flags.dn_done ? ffha_pkg::OP_DN_DONE : ffha_pkg::OP_READ_DN;
      ffha_pkg::S_DN1_WR:     op = ffha_pkg::OP_WRITE_DN;
      ffha_pkg::S_PV_RD:      op = flags.has_prev ? ffha_pkg::OP_READ_PV : ffha_pkg::OP_WB_FIN;
      ffha_pkg::S_PV_CHK:     op = flags.rd_free ? ffha_pkg::OP_MERGE_PV : ffha_pkg::OP_WB_FIN;
      ffha_pkg::S_DN2_RD:     op = flags.dn_done ? ffha_pkg::OP_DN_FIN : ffha_pkg::OP_READ_DN;
      ffha_pkg::S_DN2_WR:     op = ffha_pkg::OP_WRITE_DN;
      default:                op = ffha_pkg::OP_NONE;
    endcase
  end

endmodule

/* rtl/ffha_dp.sv */
// Datapath: block table memory, index registers, counters and config.
module ffha_dp #(
  parameter int unsigned MAX_BLOCKS   = 256,
  parameter int unsigned HEADER_BYTES = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  ffha_pkg::req_t   request,
  input  ffha_pkg::op_t    op,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data,
  output ffha_pkg::flags_t flags,
  output logic             done,
  output ffha_pkg::rsp_t   result
);

  localparam int unsigned AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned IW = $clog2(MAX_BLOCKS + 1);
  localparam logic [31:0]    HDR  = 32'(HEADER_BYTES);
  localparam logic [IW-1:0]  MAXC = IW'(MAX_BLOCKS);
  localparam int unsigned    BW   = ffha_pkg::BLK_CNT_W;

  ffha_pkg::entry_t mem [MAX_BLOCKS];

  ffha_pkg::req_t   req_q;
  ffha_pkg::entry_t ent, last, rdata;
  logic [IW-1:0]    idx, cnt;
  logic [AW-1:0]    hi;
  logic [31:0]      top, fbyt, ubyt, hbyt;
  logic [BW-1:0]    fblk, ublk;
  logic [31:0]      limit, big, maxreq;
  logic [15:0]      thr;
  logic             done_q;
  logic [31:0]      addr_q;
  ffha_pkg::status_t status_q;

  ffha_pkg::status_t pre_status;
  logic [31:0]   rem, left, grow;
  logic [32:0]   grow_top;
  logic [33:0]   app_top;
  logic          grow_fail, app_fail, full;
  logic [IW-1:0] hi_p1;
  logic [IW:0]   idx_p1w;

  logic             rd_en, wr_en;
  logic [AW-1:0]    rd_addr, wr_addr;
  ffha_pkg::entry_t wr_data;

  // pre-checks on the latched request
  always_comb begin
    pre_status = ffha_pkg::ST_OK;
    if (req_q.command == ffha_pkg::CMD_FREE) begin
      if (req_q.payload_address == 32'd0) pre_status = ffha_pkg::ST_IGNORED;
    end else if (req_q.alloc_size == 32'd0 || req_q.alloc_size > maxreq) begin
      pre_status = ffha_pkg::ST_BAD_SIZE;
    end else if (req_q.alloc_size >= big) begin
      pre_status = ffha_pkg::ST_BIG;
    end
  end

  assign rem       = ent.size - req_q.alloc_size;
  assign left      = rem - HDR;
  assign grow      = req_q.alloc_size - last.size;
  assign grow_top  = {1'b0, top} + {1'b0, grow};
  assign grow_fail = grow_top > {1'b0, limit};
  assign app_top   = {2'b00, top} + {2'b00, HDR} + {2'b00, req_q.alloc_size};
  assign app_fail  = app_top > {2'b00, limit};
  assign full      = cnt >= MAXC;
  assign hi_p1     = IW'(hi) + IW'(1);
  assign idx_p1w   = {1'b0, idx} + (IW + 1)'(1);

  always_comb begin
    flags.is_free   = (req_q.command == ffha_pkg::CMD_FREE);
    flags.pre_fail  = (pre_status != ffha_pkg::ST_OK);
    flags.scan_end  = (idx == cnt);
    if (req_q.command == ffha_pkg::CMD_FREE) begin
      flags.match = ({1'b0, rdata.start} + {1'b0, HDR}) == {1'b0, req_q.payload_address};
    end else begin
      flags.match = rdata.free && (req_q.alloc_size <= rdata.size);
    end
    flags.last_free = (cnt != '0) && last.free;
    flags.ent_free  = ent.free;
    flags.split_ok  = (rem >= HDR) && (left >= {16'd0, thr}) && (cnt < MAXC);
    flags.has_next  = hi_p1 < cnt;
    flags.has_prev  = (hi != '0);
    flags.rd_free   = rdata.free;
    flags.up_done   = (idx == hi_p1);
    flags.dn_done   = idx_p1w >= {1'b0, cnt};
  end

  // memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = hi;
    wr_data = ent;
    unique case (op)
      ffha_pkg::OP_READ_IDX: rd_en = 1'b1;
      ffha_pkg::OP_READ_UP: begin
        rd_en   = 1'b1;
        rd_addr = AW'(idx - IW'(1));
      end
      ffha_pkg::OP_READ_NX: begin
        rd_en   = 1'b1;
        rd_addr = hi_p1[AW-1:0];
      end
      ffha_pkg::OP_READ_DN: begin
        rd_en   = 1'b1;
        rd_addr = idx_p1w[AW-1:0];
      end
      ffha_pkg::OP_READ_PV: begin
        rd_en   = 1'b1;
        rd_addr = hi - AW'(1);
      end
      ffha_pkg::OP_GROW: begin
        wr_en   = !grow_fail;
        wr_addr = AW'(cnt - IW'(1));
        wr_data = '{start: last.start, size: req_q.alloc_size, free: 1'b0};
      end
      ffha_pkg::OP_APPEND: begin
        wr_en   = !full && !app_fail;
        wr_addr = cnt[AW-1:0];
        wr_data = '{start: top, size: req_q.alloc_size, free: 1'b0};
      end
      ffha_pkg::OP_WRITE_UP, ffha_pkg::OP_WRITE_DN: begin
        wr_en   = 1'b1;
        wr_addr = idx[AW-1:0];
        wr_data = rdata;
      end
      ffha_pkg::OP_SPLIT: begin
        wr_en   = 1'b1;
        wr_addr = hi_p1[AW-1:0];
        wr_data = '{start: ent.start + HDR + req_q.alloc_size, size: left, free: 1'b1};
      end
      ffha_pkg::OP_TAKE: begin
        wr_en   = 1'b1;
        wr_data = '{start: ent.start, size: ent.size, free: 1'b0};
      end
      ffha_pkg::OP_TAKE_SPLIT: begin
        wr_en   = 1'b1;
        wr_data = '{start: ent.start, size: req_q.alloc_size, free: 1'b0};
      end
      ffha_pkg::OP_MERGE_PV: begin
        wr_en   = 1'b1;
        wr_addr = hi - AW'(1);
        wr_data = '{start: rdata.start, size: rdata.size + ent.size + HDR, free: 1'b1};
      end
      ffha_pkg::OP_WB_FIN: wr_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      top    <= '0;
      fblk   <= '0;
      fbyt   <= '0;
      ublk   <= '0;
      ubyt   <= '0;
      hbyt   <= '0;
      limit  <= ffha_pkg::HEAP_LIMIT_RST;
      thr    <= ffha_pkg::SPLIT_THR_RST;
      big    <= ffha_pkg::BIG_THR_RST;
      maxreq <= ffha_pkg::MAX_REQUEST_RST;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we) begin
        unique case (ffha_pkg::cfg_index_t'(cfg_index))
          ffha_pkg::CFG_HEAP_LIMIT:  limit  <= cfg_data;
          ffha_pkg::CFG_SPLIT_THR:   thr    <= cfg_data[15:0];
          ffha_pkg::CFG_BIG_THR:     big    <= cfg_data;
          ffha_pkg::CFG_MAX_REQUEST: maxreq <= cfg_data;
          default: ;
        endcase
      end
      unique case (op)
        ffha_pkg::OP_LOAD: begin
          req_q <= request;
          idx   <= '0;
        end
        ffha_pkg::OP_FAIL: begin
          done_q   <= 1'b1;
          addr_q   <= '0;
          status_q <= pre_status;
        end
        ffha_pkg::OP_FIN_IGNORE: begin
          done_q   <= 1'b1;
          addr_q   <= '0;
          status_q <= ffha_pkg::ST_IGNORED;
        end
        ffha_pkg::OP_INC: begin
          idx  <= idx + IW'(1);
          last <= rdata;
        end
        ffha_pkg::OP_HIT: begin
          ent <= rdata;
          hi  <= idx[AW-1:0];
        end
        ffha_pkg::OP_GROW: begin
          done_q <= 1'b1;
          if (grow_fail) begin
            addr_q   <= '0;
            status_q <= ffha_pkg::ST_NO_HEAP;
          end else begin
            top      <= grow_top[31:0];
            fbyt     <= fbyt + grow - req_q.alloc_size;
            ubyt     <= ubyt + grow;
            fblk     <= fblk - BW'(1);
            addr_q   <= last.start + HDR;
            status_q <= ffha_pkg::ST_OK;
          end
        end
        ffha_pkg::OP_APPEND: begin
          done_q <= 1'b1;
          if (full) begin
            addr_q   <= '0;
            status_q <= ffha_pkg::ST_FULL;
          end else if (app_fail) begin
            addr_q   <= '0;
            status_q <= ffha_pkg::ST_NO_HEAP;
          end else begin
            cnt      <= cnt + IW'(1);
            top      <= app_top[31:0];
            ublk     <= ublk + BW'(1);
            ubyt     <= ubyt + req_q.alloc_size;
            hbyt     <= hbyt + HDR;
            addr_q   <= top + HDR;
            status_q <= ffha_pkg::ST_OK;
          end
        end
        ffha_pkg::OP_SETUP_UP: idx <= cnt;
        ffha_pkg::OP_WRITE_UP: idx <= idx - IW'(1);
        ffha_pkg::OP_SPLIT: begin
          cnt  <= cnt + IW'(1);
          ublk <= ublk + BW'(1);
          fblk <= fblk + BW'(1);
          fbyt <= fbyt + left;
          ubyt <= ubyt - HDR;
          hbyt <= hbyt + HDR;
        end
        ffha_pkg::OP_TAKE, ffha_pkg::OP_TAKE_SPLIT: begin
          fblk     <= fblk - BW'(1);
          fbyt     <= fbyt - ent.size;
          done_q   <= 1'b1;
          addr_q   <= ent.start + HDR;
          status_q <= ffha_pkg::ST_OK;
        end
        ffha_pkg::OP_MARK: begin
          ent.free <= 1'b1;
          fblk     <= fblk + BW'(1);
          fbyt     <= fbyt + ent.size;
        end
        ffha_pkg::OP_MERGE_NX: begin
          ent.size <= ent.size + rdata.size + HDR;
          idx      <= hi_p1;
          ublk     <= ublk - BW'(1);
          fblk     <= fblk - BW'(1);
          fbyt     <= fbyt + HDR;
          ubyt     <= ubyt + HDR;
          hbyt     <= hbyt - HDR;
        end
        ffha_pkg::OP_MERGE_PV: begin
          idx  <= IW'(hi);
          ublk <= ublk - BW'(1);
          fblk <= fblk - BW'(1);
          fbyt <= fbyt + HDR;
          ubyt <= ubyt + HDR;
          hbyt <= hbyt - HDR;
        end
        ffha_pkg::OP_WRITE_DN: idx <= idx_p1w[IW-1:0];
        ffha_pkg::OP_DN_DONE: cnt <= cnt - IW'(1);
        ffha_pkg::OP_DN_FIN: begin
          cnt      <= cnt - IW'(1);
          done_q   <= 1'b1;
          addr_q   <= '0;
          status_q <= ffha_pkg::ST_OK;
        end
        ffha_pkg::OP_WB_FIN: begin
          done_q   <= 1'b1;
          addr_q   <= '0;
          status_q <= ffha_pkg::ST_OK;
        end
        default: ;
      endcase
    end
  end

  assign done = done_q;

  always_comb begin
    result.result_address = addr_q;
    result.status         = status_q;
    result.avail_blocks   = fblk;
    result.avail_bytes    = fbyt;
    result.used_blocks    = ublk;
    result.used_bytes     = ubyt;
    result.header_bytes   = hbyt;
  end

endmodule

/* rtl/first_fit_heap_allocator.sv */
// Top level of the first-fit heap allocator: sequencer plus datapath.
//
// Usage:
//   Command channel: drive request and raise start; the transaction is taken
//   at a clock edge where start is high and busy is low. busy stays high
//   until the result is produced.
//   Result: done pulses for one cycle with result valid (address, status and
//   the five usage counters). The receiver cannot stall; the result must be
//   sampled in that cycle. A new command may be issued in the done cycle.
//   Config: cfg_valid/cfg_ready write channel, always ready. Index 0 heap
//   limit, 1 split threshold, 2 big threshold, 3 max request. Write only
//   while busy is low.
//   Sequencing: each table entry scanned takes a read and a check (one memory
//   port, registered read data); each entry moved when a split opens a slot
//   or a merge closes one takes a read and a write, plus setup steps. A free
//   that merges both neighbors low in a full table moves nearly every entry
//   twice. One command at a time; a new command is taken only once the
//   result is produced and busy is low.
//   Reset: table empty, heap top and counters zero, config to defaults.
//   No memory clearing pass is needed; only entries below the count are read.
module first_fit_heap_allocator #(
  parameter int unsigned MAX_BLOCKS   = 256,
  parameter int unsigned HEADER_BYTES = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  ffha_pkg::req_t request,
  output logic           done,
  output ffha_pkg::rsp_t result,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [31:0]    cfg_data
);

  ffha_pkg::op_t    op;
  ffha_pkg::flags_t flags;

  // config writes are always accepted; cfg_ready is tied high
  assign cfg_ready = 1'b1;

  ffha_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .flags (flags),
    .op    (op),
    .busy  (busy)
  );

  ffha_dp #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .op        (op),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .flags     (flags),
    .done      (done),
    .result    (result)
  );

  // result strobe only once the sequencer is back to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");

  // an accepted command always occupies the sequencer next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command not taken");

  // failures never hand out an address
  a_fail_addr: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ffha_pkg::ST_OK) |-> (result.result_address == 32'd0))
    else $error("address on failure");

  // free blocks are a subset of held blocks
  a_blk_count: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.avail_blocks <= result.used_blocks))
    else $error("free blocks exceed held blocks");

endmodule

/* tb/first_fit_heap_allocator_tb.sv */
// Self-checking testbench for the first-fit heap allocator.
`timescale 1ns / 100ps

module first_fit_heap_allocator_tb;
  import ffha_pkg::*;

  localparam int unsigned NBLK = 256;
  localparam int unsigned HDR  = 32;

  // Predicts allocator results and holds the outstanding expectations.
  class heap_scoreboard;
    logic [31:0] blk_start [NBLK];
    logic [31:0] blk_size  [NBLK];
    bit          blk_free  [NBLK];
    int unsigned blk_cnt;
    logic [31:0] top;
    logic [31:0] c_fblk, c_fbyt, c_ublk, c_ubyt, c_hbyt;
    logic [31:0] lim, big_thr, max_req;
    logic [15:0] split_thr;
    rsp_t        pending[$];
    rsp_t        last_exp;
    int          errors;

    function void reset_state();
      blk_cnt = 0; top = 0;
      c_fblk = 0; c_fbyt = 0; c_ublk = 0; c_ubyt = 0; c_hbyt = 0;
      lim = HEAP_LIMIT_RST; split_thr = SPLIT_THR_RST;
      big_thr = BIG_THR_RST; max_req = MAX_REQUEST_RST;
      pending.delete(); errors = 0;
    endfunction

    function void set_reg(cfg_index_t idx, logic [31:0] v);
      case (idx)
        CFG_HEAP_LIMIT:  lim = v;
        CFG_SPLIT_THR:   split_thr = v[15:0];
        CFG_BIG_THR:     big_thr = v;
        CFG_MAX_REQUEST: max_req = v;
      endcase
    endfunction

    function void open_slot(int unsigned pos);
      for (int unsigned k = blk_cnt; k > pos; k--) begin
        blk_start[k] = blk_start[k-1]; blk_size[k] = blk_size[k-1];
        blk_free[k] = blk_free[k-1];
      end
      blk_cnt++;
    endfunction

    // fold entry r into entry r-1
    function void merge_into_left(int unsigned r);
      c_ublk -= 1; c_fblk -= 1; c_fbyt += HDR; c_ubyt += HDR; c_hbyt -= HDR;
      blk_size[r-1] += blk_size[r] + HDR;
      for (int unsigned k = r; k + 1 < blk_cnt; k++) begin
        blk_start[k] = blk_start[k+1]; blk_size[k] = blk_size[k+1];
        blk_free[k] = blk_free[k+1];
      end
      blk_cnt--;
    endfunction

    function status_t alloc(logic [31:0] req, output logic [31:0] addr);
      int unsigned i;
      logic [63:0] rem, ntop;
      logic [31:0] grow;
      addr = 0;
      if (req == 0 || req > max_req) return ST_BAD_SIZE;
      if (req >= big_thr) return ST_BIG;
      for (i = 0; i < blk_cnt; i++)
        if (blk_free[i] && req <= blk_size[i]) break;
      if (i < blk_cnt) begin
        rem = 64'(blk_size[i]) - req;
        blk_free[i] = 0; c_fblk -= 1; c_fbyt -= blk_size[i];
        if (rem >= HDR && rem - HDR >= split_thr && blk_cnt < NBLK) begin
          c_ublk += 1; c_fblk += 1; c_fbyt += 32'(rem - HDR);
          c_ubyt -= HDR; c_hbyt += HDR;
          open_slot(i + 1);
          blk_start[i+1] = blk_start[i] + HDR + req;
          blk_size[i+1] = 32'(rem - HDR); blk_free[i+1] = 1;
          blk_size[i] = req;
        end
        addr = blk_start[i] + HDR;
        return ST_OK;
      end
      if (blk_cnt > 0 && blk_free[blk_cnt-1]) begin
        i = blk_cnt - 1;
        grow = req - blk_size[i];
        ntop = 64'(top) + grow;
        if (ntop > lim) return ST_NO_HEAP;
        top = ntop[31:0]; blk_size[i] = req;
        c_fbyt += grow; c_ubyt += grow;
        blk_free[i] = 0; c_fblk -= 1; c_fbyt -= req;
        addr = blk_start[i] + HDR;
        return ST_OK;
      end
      if (blk_cnt >= NBLK) return ST_FULL;
      ntop = 64'(top) + HDR + req;
      if (ntop > lim) return ST_NO_HEAP;
      i = blk_cnt; blk_cnt++;
      blk_start[i] = top; blk_size[i] = req; blk_free[i] = 0;
      top = ntop[31:0];
      c_ublk += 1; c_ubyt += req; c_hbyt += HDR;
      addr = blk_start[i] + HDR;
      return ST_OK;
    endfunction

    function status_t release_payload(logic [31:0] p);
      int unsigned i;
      if (p == 0) return ST_IGNORED;
      for (i = 0; i < blk_cnt; i++)
        if (64'(blk_start[i]) + HDR == 64'(p)) break;
      if (i >= blk_cnt || blk_free[i]) return ST_IGNORED;
      blk_free[i] = 1; c_fblk += 1; c_fbyt += blk_size[i];
      if (i + 1 < blk_cnt && blk_free[i+1]) merge_into_left(i + 1);
      if (i > 0 && blk_free[i-1]) merge_into_left(i);
      return ST_OK;
    endfunction

    // note an accepted command transaction
    function void note_request(req_t rq);
      rsp_t e;
      logic [31:0] a;
      a = 0;
      if (rq.command == CMD_ALLOC) e.status = alloc(rq.alloc_size, a);
      else e.status = release_payload(rq.payload_address);
      e.result_address = a;
      e.avail_blocks = c_fblk[8:0]; e.avail_bytes = c_fbyt;
      e.used_blocks = c_ublk[8:0]; e.used_bytes = c_ubyt;
      e.header_bytes = c_hbyt;
      pending.push_back(e);
      last_exp = e;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] exp);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $time);
      errors++;
    endtask

    task check_result(rsp_t r);
      rsp_t e;
      if (pending.size() == 0) begin
        $display("unexpected result at %0t", $time);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (r.result_address !== e.result_address)
        report("result_address", r.result_address, e.result_address);
      if (r.status !== e.status) report("status", r.status, e.status);
      if (r.avail_blocks !== e.avail_blocks)
        report("avail_blocks", r.avail_blocks, e.avail_blocks);
      if (r.avail_bytes !== e.avail_bytes) report("avail_bytes", r.avail_bytes, e.avail_bytes);
      if (r.used_blocks !== e.used_blocks) report("used_blocks", r.used_blocks, e.used_blocks);
      if (r.used_bytes !== e.used_bytes) report("used_bytes", r.used_bytes, e.used_bytes);
      if (r.header_bytes !== e.header_bytes)
        report("header_bytes", r.header_bytes, e.header_bytes);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  req_t        request = '0;
  logic        done;
  rsp_t        result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  heap_scoreboard sb;
  logic [31:0] live_addrs[$];   // payload addresses handed out and not yet freed
  bit          gaps_on = 1'b1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  first_fit_heap_allocator i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Results cannot be held off: every done cycle is a completed transaction.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  // Runaway guard: the worst case per command is far below this limit.
  initial begin
    #(20 * 5_000_000);
    $display("TB_ERROR");
    $finish;
  end

  // Issue one command; returns after the block has taken it.
  task automatic issue(logic cmd, logic [31:0] size, logic [31:0] addr);
    req_t rq;
    rq.command = cmd; rq.alloc_size = size; rq.payload_address = addr;
    while (gaps_on && $urandom_range(99) < 14) @(posedge clk);
    request <= rq;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    // Edge above took the transaction; predict on the same edge.
    sb.note_request(rq);
    start <= 1'b0;
    // busy is high in the following cycle, so nothing is lost by this wait
    @(posedge clk);
  endtask

  task automatic do_alloc(logic [31:0] size);
    issue(CMD_ALLOC, size, '0);
    if (sb.last_exp.status == ST_OK) live_addrs.push_back(sb.last_exp.result_address);
  endtask

  task automatic do_free_random();
    int k;
    if (live_addrs.size() == 0) begin
      issue(CMD_FREE, '0, $urandom);
      return;
    end
    k = $urandom_range(live_addrs.size() - 1);
    issue(CMD_FREE, '0, live_addrs[k]);
    live_addrs.delete(k);
  endtask

  // Drain all expected results, then let any trailing work settle.
  task automatic drain();
    while (sb.pending.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [31:0] v);
    cfg_index <= idx;
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mix of allocs and frees; size_hi bounds most request sizes.
  task automatic random_phase(int n, int unsigned size_hi);
    int unsigned r;
    for (int j = 0; j < n; j++) begin
      gaps_on = !(j >= n / 3 && j < n / 3 + 40);   // one stretch without gaps
      r = $urandom_range(99);
      if (r < 50) do_alloc($urandom_range(size_hi, 1));
      else if (r < 85) do_free_random();
      else if (r < 92) do_alloc($urandom);          // wide sizes, mostly refused
      else if (r < 96) issue(CMD_FREE, '0, $urandom);   // bogus address
      else issue(CMD_FREE, $urandom, live_addrs.size() ? live_addrs[0] + 1 : 0);
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: size extremes, refusals, split, merges, bad frees.
    do_alloc(32'd0);
    do_alloc(32'hFFFF_FFFF);
    do_alloc(32'd100_000_000);
    do_alloc(32'd128_000);
    do_alloc(32'd127_999);
    do_alloc(32'd1);
    do_alloc(32'd1000);
    do_alloc(32'd50);
    issue(CMD_FREE, '0, '0);
    issue(CMD_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(CMD_FREE, '0, 32'd32);                 // block at 0
    issue(CMD_FREE, '0, 32'd32);                 // already free
    issue(CMD_FREE, '0, 32'd32 + 32'd127_999 + 32'd32 + 32'd1 + 32'd32);   // 1000 block
    issue(CMD_FREE, '0, 32'd32 + 32'd127_999 + 32'd32);                     // merges both
    do_alloc(32'd10);                            // reuse with split
    issue(CMD_FREE, '0, 32'd32 + 32'd127_999 + 32'd32 + 32'd1 + 32'd32 + 32'd1000 + 32'd32);
    do_alloc(32'd5000);                          // reuse the free last block with a split
    live_addrs.delete();
    drain();

    // Pause sender until everything is back, then tight heap limit.
    write_reg(CFG_HEAP_LIMIT, 32'd0);
    write_reg(CFG_SPLIT_THR, 32'd0);
    write_reg(CFG_BIG_THR, 32'd1);
    write_reg(CFG_MAX_REQUEST, 32'd1);
    do_alloc(32'd1);
    do_alloc(32'd2);
    drain();
    write_reg(CFG_BIG_THR, 32'hFFFF_FFFF);
    write_reg(CFG_MAX_REQUEST, 32'hFFFF_FFFF);
    do_alloc(32'd1);                             // fits the free block, split off the rest
    do_alloc(32'hFFFF_FFFE);
    drain();

    write_reg(CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
    write_reg(CFG_SPLIT_THR, 32'd0);
    random_phase(130, 400);
    drain();

    write_reg(CFG_SPLIT_THR, 32'hFFFF);
    write_reg(CFG_HEAP_LIMIT, 32'd200_000);
    write_reg(CFG_BIG_THR, 32'd60_000);
    write_reg(CFG_MAX_REQUEST, 32'd90_000);
    random_phase(90, 70_000);
    drain();

    // Fill the table with tiny blocks to reach the full-table case.
    write_reg(CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
    write_reg(CFG_SPLIT_THR, 32'd16);
    write_reg(CFG_BIG_THR, BIG_THR_RST);
    write_reg(CFG_MAX_REQUEST, MAX_REQUEST_RST);
    while (sb.blk_cnt < NBLK) do_alloc($urandom_range(8, 1));
    do_alloc(32'd3);
    random_phase(100, 300);

    drain();
    repeat (1100) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/ffha_pkg.sv
rtl/ffha_ctrl.sv
rtl/ffha_dp.sv
rtl/first_fit_heap_allocator.sv
tb/first_fit_heap_allocator_tb.sv
